### hw/rtl/grdfs_pkg.sv
// Package: shared types and codes for the graph reachability engine.
`default_nettype none

package grdfs_pkg;

    localparam int NODE_W    = 10;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 11;
    localparam int EPOCH_W   = 8;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 16;

    localparam logic [FUNC_W-1:0] FN_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_QUERY = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_RANGE = 2'd2;

    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DECODE,
        ST_ADD_WR,
        ST_Q_START,
        ST_POP,
        ST_NODE,
        ST_HEAD,
        ST_EDGE,
        ST_VISIT,
        ST_FINISH,
        ST_RESP
    } grdfs_state_t;

endpackage

`default_nettype wire

### hw/rtl/grdfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module grdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/graph_reachability_dfs.sv
// Top level: directed graph store and depth-first reachability engine.
//
// Usage:
//   Input items arrive on s_axis; s_axis_tuser carries func (0 add edge,
//   1 query, 2 clear graph), s_axis_tdata carries the node numbers.
//   Every item gives exactly one result item on m_axis: status,
//   reachable and reached_count.
//   One item is processed at a time; s_axis_tready is high only while
//   the sequencer is idle. All work runs through one small sequencer that
//   issues at most one access per cycle to each memory (node heads,
//   edge store, visited tags, walk stack).
//   Add edge: a head read, then the edge and head write.
//   Clear: a sweep of the node head memory.
//   Query: a depth-first walk over the reached nodes and followed edges. Visited
//   marks are epoch tags; once all 255 nonzero tags are used, the next query
//   first sweeps the visited memory.
//   After reset the block sweeps the head and visited memories with
//   s_axis_tready low.
//   A finished result waits in the output register; while m_axis_tready
//   is low the next item may be accepted and runs until its own result
//   is ready, then waits for the register to drain.
`default_nettype none

module graph_reachability_dfs #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [9:0] edge_from, [19:10] edge_to, [29:20] start_node, [39:30] target_node
    input  wire logic [grdfs_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [1:0] func
    input  wire logic [grdfs_pkg::FUNC_W-1:0]    s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [1:0] status, [2] reachable, [13:3] reached_count, [15:14] zero
    output logic      [grdfs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    import grdfs_pkg::*;

    localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int LINK_W  = $clog2(MAX_EDGES + 1);
    localparam int LEVEL_W = $clog2(MAX_NODES + 1);
    localparam int EDGE_DW = LINK_W + NODE_AW;

    grdfs_state_t state_reg, state_next;

    logic [FUNC_W-1:0]   func_reg;
    logic [NODE_W-1:0]   from_reg, to_reg, start_reg, target_reg;

    logic [LINK_W-1:0]   edge_count_reg, edge_count_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [LEVEL_W-1:0]  count_reg, count_next;
    logic [LINK_W-1:0]   link_reg, link_next;
    logic [NODE_AW-1:0]  dest_reg, dest_next;
    logic [NODE_AW-1:0]  sweep_addr_reg, sweep_addr_next;
    logic                sweep_head_reg, sweep_head_next;
    logic                sweep_vis_reg, sweep_vis_next;
    logic                boot_reg, boot_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                reach_reg, reach_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_reach_reg, out_reach_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    logic                s_accept;

    logic                head_we, head_re;
    logic [NODE_AW-1:0]  head_waddr, head_raddr;
    logic [LINK_W-1:0]   head_wdata, head_rdata;

    logic                edge_we, edge_re;
    logic [EDGE_AW-1:0]  edge_waddr, edge_raddr;
    logic [EDGE_DW-1:0]  edge_wdata, edge_rdata;
    logic [NODE_AW-1:0]  edge_rd_dest;
    logic [LINK_W-1:0]   edge_rd_next;

    logic                vis_we, vis_re;
    logic [NODE_AW-1:0]  vis_waddr, vis_raddr;
    logic [EPOCH_W-1:0]  vis_wdata, vis_rdata;

    logic                stk_we, stk_re;
    logic [NODE_AW-1:0]  stk_waddr, stk_raddr;
    logic [NODE_AW-1:0]  stk_wdata, stk_rdata;

    function automatic logic node_ok(input logic [NODE_W-1:0] n);
        node_ok = (32'(n) < MAX_NODES);
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_count_reg, out_reach_reg, out_status_reg};

    assign edge_rd_dest = edge_rdata[NODE_AW-1:0];
    assign edge_rd_next = edge_rdata[EDGE_DW-1:NODE_AW];

    grdfs_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES), .AW(NODE_AW)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (head_re),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    grdfs_ram #(.WIDTH(EDGE_DW), .DEPTH(MAX_EDGES), .AW(EDGE_AW)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .re    (edge_re),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    grdfs_ram #(.WIDTH(EPOCH_W), .DEPTH(MAX_NODES), .AW(NODE_AW)) u_vis_ram (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .re    (vis_re),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    grdfs_ram #(.WIDTH(NODE_AW), .DEPTH(MAX_NODES), .AW(NODE_AW)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            edge_count_reg <= '0;
            epoch_reg      <= '0;
            level_reg      <= '0;
            count_reg      <= '0;
            link_reg       <= '0;
            sweep_addr_reg <= '0;
            sweep_head_reg <= 1'b1;
            sweep_vis_reg  <= 1'b1;
            boot_reg       <= 1'b1;
            status_reg     <= STS_OK;
            reach_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_count_reg <= edge_count_next;
            epoch_reg      <= epoch_next;
            level_reg      <= level_next;
            count_reg      <= count_next;
            link_reg       <= link_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_head_reg <= sweep_head_next;
            sweep_vis_reg  <= sweep_vis_next;
            boot_reg       <= boot_next;
            status_reg     <= status_next;
            reach_reg      <= reach_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            func_reg   <= s_axis_tuser;
            from_reg   <= s_axis_tdata[9:0];
            to_reg     <= s_axis_tdata[19:10];
            start_reg  <= s_axis_tdata[29:20];
            target_reg <= s_axis_tdata[39:30];
        end
        dest_reg       <= dest_next;
        out_status_reg <= out_status_next;
        out_reach_reg  <= out_reach_next;
        out_count_reg  <= out_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        edge_count_next = edge_count_reg;
        epoch_next      = epoch_reg;
        level_next      = level_reg;
        count_next      = count_reg;
        link_next       = link_reg;
        dest_next       = dest_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_head_next = sweep_head_reg;
        sweep_vis_next  = sweep_vis_reg;
        boot_next       = boot_reg;
        status_next     = status_reg;
        reach_next      = reach_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_reach_next  = out_reach_reg;
        out_count_next  = out_count_reg;

        head_we    = 1'b0;
        head_waddr = sweep_addr_reg;
        head_wdata = '0;
        head_re    = 1'b0;
        head_raddr = NODE_AW'(from_reg);
        edge_we    = 1'b0;
        edge_waddr = EDGE_AW'(edge_count_reg);
        edge_wdata = {head_rdata, NODE_AW'(to_reg)};
        edge_re    = 1'b0;
        edge_raddr = EDGE_AW'(head_rdata - 1'b1);
        vis_we     = 1'b0;
        vis_waddr  = sweep_addr_reg;
        vis_wdata  = '0;
        vis_re     = 1'b0;
        vis_raddr  = edge_rd_dest;
        stk_we     = 1'b0;
        stk_waddr  = NODE_AW'(level_reg);
        stk_wdata  = dest_reg;
        stk_re     = 1'b0;
        stk_raddr  = NODE_AW'(level_reg - 1'b1);

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_SWEEP:
            begin
                head_we = sweep_head_reg;
                vis_we  = sweep_vis_reg;
                if (32'(sweep_addr_reg) == MAX_NODES - 1)
                begin
                    sweep_addr_next = '0;
                    if (boot_reg)
                    begin
                        boot_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else if (func_reg == FN_QUERY)
                    begin
                        epoch_next = '0;
                        state_next = ST_Q_START;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    status_next = STS_OK;
                    reach_next  = 1'b0;
                    count_next  = '0;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (func_reg)
                    FN_ADD:
                    begin
                        if (!node_ok(from_reg) || !node_ok(to_reg))
                        begin
                            status_next = STS_RANGE;
                            state_next  = ST_RESP;
                        end
                        else if (32'(edge_count_reg) == MAX_EDGES)
                        begin
                            status_next = STS_FULL;
                            state_next  = ST_RESP;
                        end
                        else
                        begin
                            head_re    = 1'b1;
                            state_next = ST_ADD_WR;
                        end
                    end
                    FN_QUERY:
                    begin
                        if (!node_ok(start_reg) || !node_ok(target_reg))
                        begin
                            status_next = STS_RANGE;
                            state_next  = ST_RESP;
                        end
                        else
                        begin
                            state_next = ST_Q_START;
                        end
                    end
                    FN_CLEAR:
                    begin
                        edge_count_next = '0;
                        sweep_head_next = 1'b1;
                        sweep_vis_next  = 1'b0;
                        sweep_addr_next = '0;
                        state_next      = ST_SWEEP;
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_ADD_WR:
            begin
                edge_we         = 1'b1;
                head_we         = 1'b1;
                head_waddr      = NODE_AW'(from_reg);
                head_wdata      = edge_count_reg + 1'b1;
                edge_count_next = edge_count_reg + 1'b1;
                state_next      = ST_RESP;
            end
            ST_Q_START:
            begin
                if (epoch_reg == EPOCH_LAST)
                begin
                    sweep_head_next = 1'b0;
                    sweep_vis_next  = 1'b1;
                    sweep_addr_next = '0;
                    state_next      = ST_SWEEP;
                end
                else
                begin
                    epoch_next = epoch_reg + 1'b1;
                    vis_we     = 1'b1;
                    vis_waddr  = NODE_AW'(start_reg);
                    vis_wdata  = epoch_reg + 1'b1;
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = NODE_AW'(start_reg);
                    level_next = LEVEL_W'(1);
                    count_next = LEVEL_W'(1);
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (level_reg == '0)
                begin
                    vis_re     = 1'b1;
                    vis_raddr  = NODE_AW'(target_reg);
                    state_next = ST_FINISH;
                end
                else
                begin
                    stk_re     = 1'b1;
                    level_next = level_reg - 1'b1;
                    state_next = ST_NODE;
                end
            end
            ST_NODE:
            begin
                head_re    = 1'b1;
                head_raddr = stk_rdata;
                state_next = ST_HEAD;
            end
            ST_HEAD:
            begin
                if (head_rdata == '0)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    edge_re    = 1'b1;
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                vis_re     = 1'b1;
                dest_next  = edge_rd_dest;
                link_next  = edge_rd_next;
                state_next = ST_VISIT;
            end
            ST_VISIT:
            begin
                if (vis_rdata != epoch_reg)
                begin
                    vis_we     = 1'b1;
                    vis_waddr  = dest_reg;
                    vis_wdata  = epoch_reg;
                    stk_we     = 1'b1;
                    level_next = level_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                end
                if (link_reg == '0)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    edge_re    = 1'b1;
                    edge_raddr = EDGE_AW'(link_reg - 1'b1);
                    state_next = ST_EDGE;
                end
            end
            ST_FINISH:
            begin
                reach_next = (vis_rdata == epoch_reg);
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_reach_next  = reach_reg;
                    out_count_next  = COUNT_W'(count_reg);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    logic in_walk;
    assign in_walk = (state_reg == ST_POP) || (state_reg == ST_NODE) ||
                     (state_reg == ST_HEAD) || (state_reg == ST_EDGE) ||
                     (state_reg == ST_VISIT);

    a_level_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_walk |-> (level_reg <= count_reg))
        else $error("stack deeper than reached node count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_walk |-> (32'(count_reg) <= MAX_NODES))
        else $error("reached count exceeds node count");

    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        in_walk |-> (epoch_reg != '0))
        else $error("walk running with the swept epoch tag");

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(edge_count_reg) <= MAX_EDGES)
        else $error("edge count beyond edge store");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg == ST_DECODE) && !s_axis_tready)
        else $error("accepted item did not start decode");

endmodule

`default_nettype wire

### tb/sv/tb_graph_reachability_dfs.sv
// Testbench for graph_reachability_dfs: stream stimulus, DFS predictor and result checks.
module tb_graph_reachability_dfs;
    timeunit 1ns;
    timeprecision 1ps;

    import grdfs_pkg::*;

    localparam int NODES          = 1024;
    localparam int EDGES          = 4096;
    localparam int STALL_CYCLES   = 400;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_ITEMS    = 450;

    // func value with no operation behind it
    localparam logic [FUNC_W-1:0] FN_NONE = 2'd3;

    typedef struct packed {
        logic [NODE_W-1:0] target_node;
        logic [NODE_W-1:0] start_node;
        logic [NODE_W-1:0] edge_to;
        logic [NODE_W-1:0] edge_from;
    } graph_item_t;

    typedef struct packed {
        logic [1:0]          pad;
        logic [COUNT_W-1:0]  reached_count;
        logic                reachable;
        logic [STATUS_W-1:0] status;
    } reach_result_t;

    class reach_scoreboard;
        int unsigned   list_head[NODES];
        int unsigned   edge_dst[EDGES];
        int unsigned   edge_link[EDGES];
        int unsigned   edge_total;
        bit            marked[NODES];
        int unsigned   dfs_stack[NODES];
        reach_result_t expected_q[$];
        int unsigned   noted_count;
        int            errors;

        function new();
            erase_graph();
            noted_count = 0;
            errors      = 0;
        endfunction

        function void erase_graph();
            foreach (list_head[i])
                list_head[i] = 0;
            edge_total = 0;
        endfunction

        // 10-bit node numbers never exceed NODES-1, so the range error cannot occur
        function reach_result_t predict(logic [FUNC_W-1:0] fn, graph_item_t it);
            reach_result_t r;
            int unsigned   sp;
            int unsigned   node;
            int unsigned   link;
            int unsigned   d;
            r = '0;
            case (fn)
                FN_ADD:
                begin
                    if (edge_total >= EDGES)
                    begin
                        r.status = STS_FULL;
                    end
                    else
                    begin
                        edge_dst[edge_total]    = it.edge_to;
                        edge_link[edge_total]   = list_head[it.edge_from];
                        edge_total++;
                        list_head[it.edge_from] = edge_total;
                    end
                end
                FN_CLEAR:
                begin
                    erase_graph();
                end
                FN_QUERY:
                begin
                    foreach (marked[i])
                        marked[i] = 1'b0;
                    marked[it.start_node] = 1'b1;
                    dfs_stack[0]          = it.start_node;
                    sp                    = 1;
                    r.reached_count       = COUNT_W'(1);
                    while (sp > 0)
                    begin
                        sp--;
                        node = dfs_stack[sp];
                        link = list_head[node];
                        while (link != 0)
                        begin
                            d = edge_dst[link - 1];
                            if (!marked[d])
                            begin
                                marked[d]     = 1'b1;
                                dfs_stack[sp] = d;
                                sp++;
                                r.reached_count++;
                            end
                            link = edge_link[link - 1];
                        end
                    end
                    r.reachable = marked[it.target_node];
                end
                default:
                begin
                end
            endcase
            return r;
        endfunction

        function void note_item(logic [FUNC_W-1:0] fn, graph_item_t it);
            expected_q.insert(expected_q.size(), predict(fn, it));
            noted_count++;
        endfunction

        function void compare_field(string field, int unsigned exp, int unsigned act);
            if (exp != act)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp, act);
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            reach_result_t got;
            reach_result_t exp;
            got = data;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result item with none expected, expected none, actual %h",
                         $time, data);
                return;
            end
            exp = expected_q.pop_front();
            compare_field("status", exp.status, got.status);
            compare_field("reachable", exp.reachable, got.reachable);
            compare_field("reached_count", exp.reached_count, got.reached_count);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [FUNC_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    reach_scoreboard sb = new();

    int          src_idle_pct  = 0;
    int          snk_idle_pct  = 0;
    int          stall_req     = 0;
    int          stall_seen    = 0;
    int          hold_left     = 0;
    int          idle_cycles   = 0;
    int unsigned items_sent    = 0;
    int unsigned items_offered = 0;

    graph_reachability_dfs dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            sb.note_item(s_axis_tuser, s_axis_tdata);
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // receiver: random backpressure plus long hold-offs on request
    always @(posedge clk)
    begin
        if (stall_seen != stall_req)
        begin
            stall_seen    <= stall_req;
            hold_left     <= STALL_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic graph_item_t rand_item();
        graph_item_t it;
        it = IN_DATA_W'({$urandom, $urandom});
        return it;
    endfunction

    function automatic logic [NODE_W-1:0] pick_node();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? '1 : '0;
        return NODE_W'($urandom_range(NODES - 1));
    endfunction

    task automatic send_item(input logic [FUNC_W-1:0] fn, input graph_item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= it;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        items_offered++;
        if (fn != FN_NONE)
            items_sent++;
    endtask

    // unused fields keep random content
    task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b);
        graph_item_t it;
        it = rand_item();
        if (fn == FN_ADD)
        begin
            it.edge_from = a;
            it.edge_to   = b;
        end
        else if (fn == FN_QUERY)
        begin
            it.start_node  = a;
            it.target_node = b;
        end
        send_item(fn, it);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.noted_count != items_offered || sb.pending() != 0)
            @(posedge clk);
    endtask

    // small graphs on a random node pool, then queries mostly within the pool, mixed with random items
    task automatic run_random(input int unsigned n_items);
        logic [NODE_W-1:0] pool[$];
        int unsigned       stop;
        int                k;
        int                m;
        int                q;
        stop = items_sent + n_items;
        while (items_sent < stop)
        begin
            if ($urandom_range(99) < 10)
            begin
                send_item(FUNC_W'($urandom_range(3)), rand_item());
                continue;
            end
            if ($urandom_range(99) < 70)
                send_op(FN_CLEAR, '0, '0);
            pool.delete();
            k = $urandom_range(24, 1);
            repeat (k)
                pool.insert(pool.size(), pick_node());
            m = $urandom_range(3 * k, 0);
            repeat (m)
                send_op(FN_ADD, pool[$urandom_range(k - 1)], pool[$urandom_range(k - 1)]);
            q = $urandom_range(6, 1);
            repeat (q)
            begin
                if ($urandom_range(9) == 0)
                    send_op(FN_QUERY, pick_node(), pick_node());
                else
                    send_op(FN_QUERY, pool[$urandom_range(k - 1)], pool[$urandom_range(k - 1)]);
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_op(FN_CLEAR, '0, '0);
        send_op(FN_QUERY, 10'd0, 10'd0);
        send_op(FN_QUERY, 10'd0, 10'd1023);
        send_op(FN_ADD, 10'd0, 10'd1023);
        send_op(FN_ADD, 10'd1023, 10'd0);
        send_op(FN_ADD, 10'd5, 10'd5);
        send_op(FN_ADD, 10'd0, 10'd1023);
        send_op(FN_ADD, 10'd1023, 10'd512);
        send_op(FN_QUERY, 10'd0, 10'd512);
        send_op(FN_QUERY, 10'd512, 10'd0);
        send_op(FN_QUERY, 10'd5, 10'd5);
        send_item(FN_NONE, '1);
        send_item(FN_NONE, '0);
        send_item(FN_ADD, '1);
        send_item(FN_QUERY, '1);
        send_item(FN_ADD, '0);
        send_item(FN_QUERY, '0);
        send_item(FN_CLEAR, '1);
        send_op(FN_QUERY, 10'd0, 10'd1023);
        send_op(FN_QUERY, 10'd1023, 10'd1023);

        // fill the edge store past its end, walk the big graph, then empty it
        wait_drained();
        repeat (EDGES + 4)
            send_op(FN_ADD, pick_node(), pick_node());
        repeat (2)
            send_op(FN_QUERY, pick_node(), pick_node());
        send_op(FN_CLEAR, '0, '0);

        src_idle_pct = 23;
        snk_idle_pct <= 45;
        stall_req    <= stall_req + 1;
        run_random(PHASE_ITEMS);

        src_idle_pct = 45;
        snk_idle_pct <= 23;
        run_random(PHASE_ITEMS);

        src_idle_pct = 0;
        snk_idle_pct <= 0;
        stall_req    <= stall_req + 1;
        run_random(PHASE_ITEMS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
